### sv/adpcm2_pkg.sv
// Package: shared types, constants and step table for the 2-bit ADPCM encoder.
`timescale 1ns / 1ps
`default_nettype none
package adpcm2_pkg;

  typedef struct packed {
    logic [7:0] sample_ulaw;
    logic       first_sample;
    logic       last_sample;
  } sample_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } pkt_t;

  // One queued work item: optional header snapshot, optional data byte.
  typedef struct packed {
    logic        hdr;
    logic [15:0] pred;
    logic [6:0]  index;
    logic        emit;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [6:0] MAX_INDEX = 7'd88;
  localparam logic signed [17:0] PRED_MAX = 18'sd32767;
  localparam logic signed [17:0] PRED_MIN = -18'sd32768;
  localparam logic [15:0] MULAW_BIAS = 16'h0084;

  localparam logic [14:0] STEP_SIZE [0:88] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  function automatic logic [14:0] step_lookup(input logic [6:0] idx);
    logic [14:0] s;
    if (idx > MAX_INDEX) begin
      s = STEP_SIZE[88];
    end else begin
      s = STEP_SIZE[idx];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### sv/adpcm_2bit_encoder_unit.sv
// Top level: 2-bit ADPCM encoder for a mu-law sample stream, packed into bytes.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one mu-law sample per cycle and codes it in the same cycle it is
// taken; the predictor, step index and packing state update at that edge.
// Bytes leave at one per cycle when not stalled, through a registered output.
// A sample that completes a byte, or ends a packet, yields one data byte; a
// packet start adds HEADER_BYTES header beats (predictor high, predictor low,
// index, zero padding) ahead of it, so output bandwidth, not the coder, sets
// throughput at packet starts. A four-entry command queue sits between the
// coder and the byte sequencer; sample_stall rises only when it is full.
module adpcm_2bit_encoder_unit #(
  parameter int HEADER_BYTES = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample_valid,
  output logic                     sample_stall,
  input  wire adpcm2_pkg::sample_t sample_item,
  output logic                     pkt_valid,
  input  wire logic                pkt_stall,
  output adpcm2_pkg::pkt_t         pkt_item
);
  import adpcm2_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_out;
  logic push;
  logic pop;
  logic full;
  logic empty;
  logic take;

  assign sample_stall = full;
  assign take         = sample_valid && !full;

  adpcm2_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (sample_item),
    .cmd      (cmd_in),
    .cmd_push (push)
  );

  adpcm2_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .pop   (pop),
    .rdata (cmd_out),
    .full  (full),
    .empty (empty)
  );

  adpcm2_back #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .empty     (empty),
    .pop       (pop),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt_item  (pkt_item)
  );

endmodule
`default_nettype wire

### sv/adpcm2_front.sv
// Front end: mu-law expansion, ADPCM code update and code packing.
`timescale 1ns / 1ps
`default_nettype none
module adpcm2_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire adpcm2_pkg::sample_t item,
  output adpcm2_pkg::cmd_t        cmd,
  output logic                    cmd_push
);
  import adpcm2_pkg::*;

  logic signed [15:0] pred;
  logic [6:0]         index;
  logic [1:0]         pos;
  logic [7:0]         partial;

  logic signed [15:0] pred_next;
  logic [6:0]         index_next;
  logic [1:0]         pos_next;
  logic [7:0]         partial_next;

  logic [7:0]         u;
  logic [15:0]        shifted;
  logic [15:0]        mag;
  logic signed [17:0] lin;
  logic signed [17:0] diff;
  logic [17:0]        absd;
  logic               neg;
  logic               ge;
  logic [14:0]        step;
  logic [16:0]        vp;
  logic signed [17:0] sum;
  logic [1:0]         code;
  logic [1:0]         pos_eff;
  logic [7:0]         packed_byte;
  logic [7:0]         idx_up;
  logic               emit;

  always_comb begin
    u       = ~item.sample_ulaw;
    shifted = ({9'd0, u[3:0], 3'd0} + MULAW_BIAS) << u[6:4];
    mag     = shifted - MULAW_BIAS;
    lin     = u[7] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    diff    = lin - 18'(pred);
    neg     = diff[17];
    absd    = neg ? 18'(-diff) : 18'(diff);
    step    = step_lookup(index);
    ge      = absd >= {3'd0, step};
    vp      = {3'd0, step[14:1]} + (ge ? {2'd0, step} : 17'd0);
    sum     = neg ? (18'(pred) - $signed({1'b0, vp})) : (18'(pred) + $signed({1'b0, vp}));
    priority if (sum > PRED_MAX) begin
      pred_next = 16'sh7fff;
    end else if (sum < PRED_MIN) begin
      pred_next = 16'sh8000;
    end else begin
      pred_next = sum[15:0];
    end
    code   = {neg, ge};
    idx_up = {1'b0, index} + 8'd8;
    priority if (ge) begin
      index_next = (idx_up > {1'b0, MAX_INDEX}) ? MAX_INDEX : idx_up[6:0];
    end else if (index != 7'd0) begin
      index_next = index - 7'd1;
    end else begin
      index_next = 7'd0;
    end
    pos_eff = item.first_sample ? 2'd0 : pos;
    if (pos_eff == 2'd0) begin
      packed_byte = {code, 6'd0};
    end else begin
      packed_byte = partial | ({6'd0, code} << (3'd6 - {pos_eff, 1'b0}));
    end
    emit = (pos_eff == 2'd3) || item.last_sample;
    if (emit) begin
      pos_next     = 2'd0;
      partial_next = 8'd0;
    end else begin
      pos_next     = pos_eff + 2'd1;
      partial_next = packed_byte;
    end
    cmd.hdr   = item.first_sample;
    cmd.pred  = pred;
    cmd.index = index;
    cmd.emit  = emit;
    cmd.data  = packed_byte;
    cmd.last  = item.last_sample || (pos_eff == 2'd3 && item.last_sample);
    cmd_push  = take && (item.first_sample || emit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pred    <= '0;
      index   <= '0;
      pos     <= '0;
      partial <= '0;
    end else if (take) begin
      pred    <= pred_next;
      index   <= index_next;
      pos     <= pos_next;
      partial <= partial_next;
    end
  end

endmodule
`default_nettype wire

### sv/adpcm2_fifo.sv
// Small command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
`default_nettype none
module adpcm2_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire adpcm2_pkg::cmd_t wdata,
  input  wire logic             pop,
  output adpcm2_pkg::cmd_t      rdata,
  output logic                  full,
  output logic                  empty
);
  import adpcm2_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(QDEPTH);
  assign empty = count == '0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/adpcm2_back.sv
// Back end: walks each queued command through header and data beats.
`timescale 1ns / 1ps
`default_nettype none
module adpcm2_back #(
  parameter int HEADER_BYTES = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire adpcm2_pkg::cmd_t cmd,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  pkt_valid,
  input  wire logic             pkt_stall,
  output adpcm2_pkg::pkt_t      pkt_item
);
  import adpcm2_pkg::*;

  localparam int CNT_W = $clog2(HEADER_BYTES + 1);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             advance;
  logic             load;
  logic             data_phase;
  logic             hdr_end;
  logic             done;
  pkt_t             beat;

  always_comb begin
    advance    = !pkt_valid || !pkt_stall;
    load       = advance && !empty;
    data_phase = !cmd.hdr || (cnt == CNT_W'(HEADER_BYTES));
    hdr_end    = cmd.hdr && (cnt == CNT_W'(HEADER_BYTES - 1)) && !cmd.emit;
    done       = data_phase || hdr_end;
    pop        = load && done;
    cnt_next   = done ? '0 : cnt + CNT_W'(1);
    if (data_phase) begin
      beat.out_byte  = cmd.data;
      beat.last_byte = cmd.last;
    end else begin
      beat.last_byte = 1'b0;
      priority if (cnt == CNT_W'(0)) begin
        beat.out_byte = cmd.pred[15:8];
      end else if (cnt == CNT_W'(1)) begin
        beat.out_byte = cmd.pred[7:0];
      end else if (cnt == CNT_W'(2)) begin
        beat.out_byte = {1'b0, cmd.index};
      end else begin
        beat.out_byte = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
      cnt       <= '0;
    end else if (load) begin
      pkt_valid <= 1'b1;
      cnt       <= cnt_next;
    end else if (advance) begin
      pkt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pkt_item <= beat;
    end
  end

endmodule
`default_nettype wire
